[src/vpss_pkg.sv]
// Package for the vacuum pump station sequencer.
// Holds field widths, register indexes, phase and error codes and timing constants.
// No dependencies.
package vpss_pkg;

  localparam int TimerW    = 32;
  localparam int LogW      = 13;
  localparam int SpeedW    = 12;
  localparam int PhaseW    = 4;
  localparam int ErrW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;

  localparam int EvacMinW  = 7;
  localparam int CycleSecW = 10;
  localparam int OnLevelW  = 9;
  localparam int OffLevelW = 12;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegEvacTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegForeCycle   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegForeOn      = 2'd2;
  localparam logic [CfgIdxW-1:0] RegForeOff     = 2'd3;

  // Register reset values.
  localparam logic [EvacMinW-1:0]  EvacTimeoutRst = 7'd60;
  localparam logic [CycleSecW-1:0] ForeCycleRst   = 10'd20;
  localparam logic [OnLevelW-1:0]  ForeOnRst      = 9'd154;
  localparam logic [OffLevelW-1:0] ForeOffRst     = 12'hB00;  // -1280

  // Phase codes as shown on the phase output.
  localparam logic [PhaseW-1:0] PhaseOff       = 4'd0;
  localparam logic [PhaseW-1:0] PhaseStartFore = 4'd1;
  localparam logic [PhaseW-1:0] PhaseEvacFore  = 4'd2;
  localparam logic [PhaseW-1:0] PhaseEvacMain  = 4'd3;
  localparam logic [PhaseW-1:0] PhaseRampTurbo = 4'd4;
  localparam logic [PhaseW-1:0] PhaseRunFpOn   = 4'd5;
  localparam logic [PhaseW-1:0] PhaseRunFpOff  = 4'd6;
  localparam logic [PhaseW-1:0] PhaseRunFpUp   = 4'd7;
  localparam logic [PhaseW-1:0] PhaseRunFpDown = 4'd8;
  localparam logic [PhaseW-1:0] PhaseError     = 4'd9;

  // Error codes.
  localparam logic [ErrW-1:0] ErrNone      = 2'd0;
  localparam logic [ErrW-1:0] ErrForeVac   = 2'd1;
  localparam logic [ErrW-1:0] ErrMainVac   = 2'd2;
  localparam logic [ErrW-1:0] ErrTurboSlow = 2'd3;

  // Timing in 10 ms ticks.
  localparam logic [TimerW-1:0] ForeStartTicks  = TimerW'(5 * 100);
  localparam logic [TimerW-1:0] BufferTmoTicks  = TimerW'(15 * 60 * 100);
  localparam logic [TimerW-1:0] TurboTmoTicks   = TimerW'(15 * 6 * 100);
  localparam logic [TimerW-1:0] ForeSettleTicks = TimerW'(3 * 100);
  localparam int               TicksPerMinute  = 60 * 100;
  localparam int               TicksPerSecond  = 100;

  localparam logic [SpeedW-1:0] TurboMinHz = SpeedW'(800);

endpackage

[src/vacuum_pump_station_sequencer_unit.sv]
// Top level of the vacuum pump station sequencer.
// Depends on vpss_pkg (scoped references only).
//
// Each accepted item is one poll pass of the station controller; each pass
// yields exactly one result item. Passes go through two register stages: an
// input register, then the rule logic, which updates the station state and
// loads the result register. A new item is taken every cycle as long as the
// result register is empty or being drained, so throughput is one item per
// clock; while the output stalls, an item waits in the input register. The rule
// chain is a single pass of short logic: one 32-bit elapsed-time subtract
// shared by all timeout checks (any rule that restarts the phase timer forces
// the elapsed time seen by later rules to zero), plus a handful of pressure,
// speed and limit compares. A rising edge of the station or lock button
// toggles that setting; a release of the menu button (unless init_pass is
// set) returns the current state with menu_request high and skips all rules.
// Configuration registers may be written only while no item is in flight.
module vacuum_pump_station_sequencer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [vpss_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [vpss_pkg::CfgDataW-1:0]       cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [vpss_pkg::TimerW-1:0]         now_ticks_i,
  input  logic signed [vpss_pkg::LogW-1:0]    fore_log_pressure_i,
  input  logic signed [vpss_pkg::LogW-1:0]    main_log_pressure_i,
  input  logic [vpss_pkg::SpeedW-1:0]         turbo_speed_hz_i,
  input  logic                                station_button_i,
  input  logic                                lock_button_i,
  input  logic                                menu_button_i,
  input  logic                                init_pass_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                fore_pump_o,
  output logic                                fore_valve_o,
  output logic                                main_valve_o,
  output logic                                bypass_valve_o,
  output logic                                turbo_run_o,
  output logic                                vent_enable_o,
  output logic                                station_active_o,
  output logic                                valves_locked_o,
  output logic [vpss_pkg::PhaseW-1:0]         phase_o,
  output logic [vpss_pkg::ErrW-1:0]           error_code_o,
  output logic                                menu_request_o
);

  typedef enum logic [vpss_pkg::PhaseW-1:0] {
    PH_OFF        = vpss_pkg::PhaseOff,
    PH_START_FORE = vpss_pkg::PhaseStartFore,
    PH_EVAC_FORE  = vpss_pkg::PhaseEvacFore,
    PH_EVAC_MAIN  = vpss_pkg::PhaseEvacMain,
    PH_RAMP_TURBO = vpss_pkg::PhaseRampTurbo,
    PH_RUN_FPON   = vpss_pkg::PhaseRunFpOn,
    PH_RUN_FPOFF  = vpss_pkg::PhaseRunFpOff,
    PH_RUN_FPUP   = vpss_pkg::PhaseRunFpUp,
    PH_RUN_FPDOWN = vpss_pkg::PhaseRunFpDown,
    PH_ERROR      = vpss_pkg::PhaseError
  } phase_e;

  // Relay bit positions.
  localparam int RlFp = 0;
  localparam int RlFv = 1;
  localparam int RlMv = 2;
  localparam int RlBv = 3;

  localparam int EvacTicksW  = vpss_pkg::EvacMinW + 13;   // 127 * 6000 < 2^20
  localparam int CycleTicksW = vpss_pkg::CycleSecW + 7;   // 1023 * 100 < 2^17

  // ---------------------------------------------------------------- config
  logic [vpss_pkg::EvacMinW-1:0]  evac_min_q;
  logic [vpss_pkg::CycleSecW-1:0] cycle_sec_q;
  logic [vpss_pkg::OnLevelW-1:0]  on_level_q;
  logic [vpss_pkg::OffLevelW-1:0] off_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evac_min_q  <= vpss_pkg::EvacTimeoutRst;
      cycle_sec_q <= vpss_pkg::ForeCycleRst;
      on_level_q  <= vpss_pkg::ForeOnRst;
      off_level_q <= vpss_pkg::ForeOffRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vpss_pkg::RegEvacTimeout: evac_min_q  <= cfg_data_i[vpss_pkg::EvacMinW-1:0];
        vpss_pkg::RegForeCycle:   cycle_sec_q <= cfg_data_i[vpss_pkg::CycleSecW-1:0];
        vpss_pkg::RegForeOn:      on_level_q  <= cfg_data_i[vpss_pkg::OnLevelW-1:0];
        vpss_pkg::RegForeOff:     off_level_q <= cfg_data_i[vpss_pkg::OffLevelW-1:0];
        default: ;
      endcase
    end
  end

  // Limits in ticks: small constant multiplies of the register values.
  logic [EvacTicksW-1:0]  evac_ticks;
  logic [CycleTicksW-1:0] cycle_ticks;

  assign evac_ticks  = EvacTicksW'(evac_min_q) * EvacTicksW'(vpss_pkg::TicksPerMinute);
  assign cycle_ticks = CycleTicksW'(cycle_sec_q) * CycleTicksW'(vpss_pkg::TicksPerSecond);

  // ---------------------------------------------------------- pipeline ctl
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;
  logic s1_fire;

  // Result register frees up when empty or being taken this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------- input stage
  logic [vpss_pkg::TimerW-1:0]      now_q;
  logic signed [vpss_pkg::LogW-1:0] fore_q;
  logic signed [vpss_pkg::LogW-1:0] main_q;
  logic [vpss_pkg::SpeedW-1:0]      speed_q;
  logic                             b_station_q;
  logic                             b_lock_q;
  logic                             b_menu_q;
  logic                             init_q;

  // Hold the item while it waits for the result register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q       <= now_ticks_i;
      fore_q      <= fore_log_pressure_i;
      main_q      <= main_log_pressure_i;
      speed_q     <= turbo_speed_hz_i;
      b_station_q <= station_button_i;
      b_lock_q    <= lock_button_i;
      b_menu_q    <= menu_button_i;
      init_q      <= init_pass_i;
    end
  end

  // ---------------------------------------------------------- station state
  phase_e                      phase_q, phase_d;
  logic [vpss_pkg::TimerW-1:0] phase_start_q, phase_start_d;
  logic                        station_q, station_d;
  logic                        lock_q, lock_d;
  logic [2:0]                  btn_hist_q, btn_hist_d;
  logic [1:0]                  set_hist_q, set_hist_d;
  logic [3:0]                  relay_q, relay_d;
  logic                        turbo_q, turbo_d;
  logic                        vent_q, vent_d;
  logic [vpss_pkg::ErrW-1:0]   err_q, err_d;
  logic                        menu_d;

  // Pressure compare operands, all widened to 14-bit signed.
  logic signed [vpss_pkg::LogW:0] fore_x;
  logic signed [vpss_pkg::LogW:0] on_x;
  logic signed [vpss_pkg::LogW:0] off_x;
  logic [vpss_pkg::TimerW-1:0]    elapsed;
  logic                           fore_ok;
  logic                           main_ok;
  logic                           slow;
  logic                           fast;

  assign fore_x  = {fore_q[vpss_pkg::LogW-1], fore_q};
  assign on_x    = {{(vpss_pkg::LogW + 1 - vpss_pkg::OnLevelW){1'b0}}, on_level_q};
  assign off_x   = {{(vpss_pkg::LogW + 1 - vpss_pkg::OffLevelW){off_level_q[vpss_pkg::OffLevelW-1]}},
                    off_level_q};
  assign elapsed = now_q - phase_start_q;   // wraps modulo 2^TimerW
  assign fore_ok = fore_q[vpss_pkg::LogW-1];  // below 1 mbar
  assign main_ok = main_q[vpss_pkg::LogW-1];
  assign slow    = speed_q < vpss_pkg::TurboMinHz;
  assign fast    = speed_q > vpss_pkg::TurboMinHz;

  always_comb begin
    logic restarted;   // timer restarted earlier in this pass: elapsed is zero
    restarted     = 1'b0;
    phase_d       = phase_q;
    relay_d       = relay_q;
    turbo_d       = turbo_q;
    vent_d        = vent_q;
    err_d         = err_q;
    btn_hist_d    = btn_hist_q;
    set_hist_d    = set_hist_q;

    // Toggles on rising button edges; kept even on a menu pass.
    station_d = station_q ^ (b_station_q & ~btn_hist_q[0]);
    lock_d    = lock_q ^ (b_lock_q & ~btn_hist_q[1]);

    menu_d = !init_q && !b_menu_q && btn_hist_q[2];

    if (!menu_d) begin
      btn_hist_d = {b_menu_q, b_lock_q, b_station_q};

      // Station switched on: start the fore pump.
      if (station_d && !set_hist_q[0]) begin
        vent_d        = 1'b0;
        relay_d[RlMv] = 1'b0;
        relay_d[RlBv] = 1'b0;
        relay_d[RlFp] = 1'b1;
        phase_d       = PH_START_FORE;
        restarted     = 1'b1;
      end

      if (phase_d == PH_START_FORE && !restarted && elapsed > vpss_pkg::ForeStartTicks) begin
        relay_d[RlFv] = 1'b1;
        phase_d       = PH_EVAC_FORE;
        restarted     = 1'b1;
      end

      if (phase_d == PH_EVAC_FORE && !restarted && elapsed > vpss_pkg::BufferTmoTicks) begin
        phase_d       = PH_ERROR;
        err_d         = vpss_pkg::ErrForeVac;
        relay_d[RlFv] = 1'b0;
        relay_d[RlFp] = 1'b0;
      end

      // Buffer done: bypass, or turbo if locked; if main is already low, neither.
      if (phase_d == PH_EVAC_FORE && fore_ok) begin
        restarted = 1'b1;
        if (main_ok) begin
          phase_d = PH_EVAC_MAIN;
        end else if (lock_d) begin
          turbo_d       = 1'b1;
          relay_d[RlFv] = 1'b1;
          phase_d       = PH_RAMP_TURBO;
        end else begin
          relay_d[RlFv] = 1'b0;
          relay_d[RlBv] = 1'b1;
          phase_d       = PH_EVAC_MAIN;
        end
      end

      if (phase_d == PH_EVAC_MAIN && !restarted &&
          elapsed > vpss_pkg::TimerW'(evac_ticks)) begin
        phase_d       = PH_ERROR;
        err_d         = vpss_pkg::ErrMainVac;
        relay_d[RlFv] = 1'b0;
        relay_d[RlFp] = 1'b0;
      end

      if (phase_d == PH_EVAC_MAIN && main_ok) begin
        relay_d[RlFv] = 1'b1;
      end

      if (phase_d == PH_EVAC_MAIN && main_ok && fore_ok) begin
        turbo_d   = 1'b1;
        phase_d   = PH_RAMP_TURBO;
        restarted = 1'b1;
      end

      if (phase_d == PH_RAMP_TURBO && slow && !restarted &&
          elapsed > vpss_pkg::TurboTmoTicks) begin
        phase_d = PH_ERROR;
        err_d   = vpss_pkg::ErrTurboSlow;
      end

      if (phase_d == PH_RAMP_TURBO && fast && main_ok && fore_ok) begin
        relay_d[RlBv] = 1'b0;
        if (!lock_d) begin
          relay_d[RlMv] = 1'b1;
        end
        phase_d   = PH_RUN_FPON;
        restarted = 1'b1;
      end

      // Fore pump cycling with hysteresis.
      if (phase_d == PH_RUN_FPON && !restarted &&
          elapsed > vpss_pkg::TimerW'(cycle_ticks) && fore_x < off_x) begin
        relay_d[RlFv] = 1'b0;
        phase_d       = PH_RUN_FPDOWN;
        restarted     = 1'b1;
      end

      if (phase_d == PH_RUN_FPDOWN && !restarted && elapsed > vpss_pkg::ForeSettleTicks) begin
        relay_d[RlFp] = 1'b0;
        phase_d       = PH_RUN_FPOFF;
      end

      if (phase_d == PH_RUN_FPOFF && fore_x > on_x) begin
        relay_d[RlFp] = 1'b1;
        phase_d       = PH_RUN_FPUP;
        restarted     = 1'b1;
      end

      if (phase_d == PH_RUN_FPUP && !restarted && elapsed > vpss_pkg::ForeSettleTicks) begin
        relay_d[RlFv] = 1'b1;
        phase_d       = PH_RUN_FPON;
      end

      // Station switched off: drop everything and clear the error.
      if (!station_d && set_hist_q[0]) begin
        relay_d = '0;
        turbo_d = 1'b0;
        vent_d  = 1'b1;
        phase_d = PH_OFF;
        err_d   = vpss_pkg::ErrNone;
      end

      if (lock_d && !set_hist_q[1]) begin
        relay_d[RlMv] = 1'b0;
      end

      // Lock released while the station is on: re-evacuate from the buffer stage.
      if (!lock_d && set_hist_q[1] && station_d) begin
        phase_d       = PH_EVAC_FORE;
        relay_d[RlFp] = 1'b1;
        relay_d[RlFv] = 1'b1;
        restarted     = 1'b1;
      end

      set_hist_d = {lock_d, station_d};
    end

    phase_start_d = restarted ? now_q : phase_start_q;
  end

  // State and result registers advance together on each pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_OFF;
      phase_start_q    <= '0;
      station_q        <= 1'b0;
      lock_q           <= 1'b0;
      btn_hist_q       <= '0;
      set_hist_q       <= '0;
      relay_q          <= '0;
      turbo_q          <= 1'b0;
      vent_q           <= 1'b1;
      err_q            <= vpss_pkg::ErrNone;
      fore_pump_o      <= 1'b0;
      fore_valve_o     <= 1'b0;
      main_valve_o     <= 1'b0;
      bypass_valve_o   <= 1'b0;
      turbo_run_o      <= 1'b0;
      vent_enable_o    <= 1'b1;
      station_active_o <= 1'b0;
      valves_locked_o  <= 1'b0;
      phase_o          <= vpss_pkg::PhaseOff;
      error_code_o     <= vpss_pkg::ErrNone;
      menu_request_o   <= 1'b0;
    end else if (s1_fire) begin
      phase_q          <= phase_d;
      phase_start_q    <= phase_start_d;
      station_q        <= station_d;
      lock_q           <= lock_d;
      btn_hist_q       <= btn_hist_d;
      set_hist_q       <= set_hist_d;
      relay_q          <= relay_d;
      turbo_q          <= turbo_d;
      vent_q           <= vent_d;
      err_q            <= err_d;
      fore_pump_o      <= relay_d[RlFp];
      fore_valve_o     <= relay_d[RlFv];
      main_valve_o     <= relay_d[RlMv];
      bypass_valve_o   <= relay_d[RlBv];
      turbo_run_o      <= turbo_d;
      vent_enable_o    <= vent_d;
      station_active_o <= station_d;
      valves_locked_o  <= lock_d;
      phase_o          <= phase_d;
      error_code_o     <= err_d;
      menu_request_o   <= menu_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/vpss_checker.sv]
// Port-level checker for the vacuum pump station sequencer, with its bind.
// Depends on vpss_pkg and vacuum_pump_station_sequencer_unit.
module vpss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          fore_pump_o,
  input logic                          turbo_run_o,
  input logic                          vent_enable_o,
  input logic                          station_active_o,
  input logic                          menu_request_o,
  input logic [vpss_pkg::PhaseW-1:0]   phase_o,
  input logic [vpss_pkg::ErrW-1:0]     error_code_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o) && $stable(error_code_o))
    else $error("result item changed while stalled");

  // Off phase means pumps stopped, venting allowed, no error.
  a_off_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == vpss_pkg::PhaseOff |->
      !fore_pump_o && !turbo_run_o && vent_enable_o && error_code_o == vpss_pkg::ErrNone)
    else $error("off phase with pumps or error active");

  // A regular pass with the station off leaves the phase off.
  a_station_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !station_active_o && !menu_request_o |-> phase_o == vpss_pkg::PhaseOff)
    else $error("station off but phase not off");

endmodule

bind vacuum_pump_station_sequencer_unit vpss_checker u_vpss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .fore_pump_o      (fore_pump_o),
  .turbo_run_o      (turbo_run_o),
  .vent_enable_o    (vent_enable_o),
  .station_active_o (station_active_o),
  .menu_request_o   (menu_request_o),
  .phase_o          (phase_o),
  .error_code_o     (error_code_o)
);

[test/vpss_station_checker.sv]
// Checker for the vacuum pump station sequencer: predicts each poll result and compares it.
// Watches the configuration port and both item channels; depends on vpss_pkg.
module vpss_station_checker
  import vpss_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [TimerW-1:0]          now_ticks_i,
  input  logic signed [LogW-1:0]     fore_log_pressure_i,
  input  logic signed [LogW-1:0]     main_log_pressure_i,
  input  logic [SpeedW-1:0]          turbo_speed_hz_i,
  input  logic                       station_button_i,
  input  logic                       lock_button_i,
  input  logic                       menu_button_i,
  input  logic                       init_pass_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       fore_pump_i,
  input  logic                       fore_valve_i,
  input  logic                       main_valve_i,
  input  logic                       bypass_valve_i,
  input  logic                       turbo_run_i,
  input  logic                       vent_enable_i,
  input  logic                       station_active_i,
  input  logic                       valves_locked_i,
  input  logic [PhaseW-1:0]          phase_i,
  input  logic [ErrW-1:0]            error_code_i,
  input  logic                       menu_request_i,
  output int                         pending_o,
  output int                         fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic fore_pump, fore_valve, main_valve, bypass_valve;
    logic turbo_run, vent_enable, station_active, valves_locked;
    logic [PhaseW-1:0] phase;
    logic [ErrW-1:0]   error_code;
    logic              menu_request;
  } station_out_t;

  // Predicted station state.
  logic [PhaseW-1:0]  st_phase;
  logic [TimerW-1:0]  st_start;
  logic               st_station, st_lock;
  logic [2:0]         btn_seen;   // menu, lock, station as of the last full pass
  logic [1:0]         set_seen;   // lock, station as of the last full pass
  logic               fp, fv, mv, bv, turbo_cmd, vent_on;
  logic [ErrW-1:0]    st_err;

  // Predicted register contents.
  logic [EvacMinW-1:0]         evac_min;
  logic [CycleSecW-1:0]        cycle_sec;
  logic [OnLevelW-1:0]         on_level;
  logic signed [OffLevelW-1:0] off_level;

  station_out_t expected_results[$];
  station_out_t want;
  int           fail_total;

  function automatic logic [TimerW-1:0] ticks_since(input logic [TimerW-1:0] now);
    return now - st_start;
  endfunction

  function automatic station_out_t poll_pass(
    input logic [TimerW-1:0]      now,
    input logic signed [LogW-1:0] fore,
    input logic signed [LogW-1:0] mainp,
    input logic [SpeedW-1:0]      speed,
    input logic                   b_st, b_lk, b_mn, b_init
  );
    station_out_t r;
    logic menu, fore_ok, main_ok;
    int fore_v, main_v, on_v, off_v;
    fore_v  = fore;
    main_v  = mainp;
    on_v    = on_level;
    off_v   = off_level;
    fore_ok = fore_v < 0;
    main_ok = main_v < 0;
    menu    = 1'b0;

    if (b_st && !btn_seen[0]) st_station = !st_station;
    if (b_lk && !btn_seen[1]) st_lock = !st_lock;

    if (!b_init && !b_mn && btn_seen[2]) begin
      menu = 1'b1;
    end else begin
      btn_seen = {b_mn, b_lk, b_st};

      if (st_station && !set_seen[0]) begin
        vent_on  = 1'b0;
        mv       = 1'b0;
        bv       = 1'b0;
        fp       = 1'b1;
        st_phase = PhaseStartFore;
        st_start = now;
      end

      if (st_phase == PhaseStartFore && ticks_since(now) > ForeStartTicks) begin
        fv       = 1'b1;
        st_start = now;
        st_phase = PhaseEvacFore;
      end

      if (st_phase == PhaseEvacFore && ticks_since(now) > BufferTmoTicks) begin
        st_phase = PhaseError;
        st_err   = ErrForeVac;
        fv       = 1'b0;
        fp       = 1'b0;
      end

      if (st_phase == PhaseEvacFore && fore_ok) begin
        st_start = now;
        if (main_ok) begin
          st_phase = PhaseEvacMain;
        end else if (st_lock) begin
          turbo_cmd = 1'b1;
          fv        = 1'b1;
          st_phase  = PhaseRampTurbo;
        end else begin
          fv       = 1'b0;
          bv       = 1'b1;
          st_phase = PhaseEvacMain;
        end
      end

      if (st_phase == PhaseEvacMain &&
          longint'(ticks_since(now)) > longint'(evac_min) * TicksPerMinute) begin
        st_phase = PhaseError;
        st_err   = ErrMainVac;
        fv       = 1'b0;
        fp       = 1'b0;
      end

      if (st_phase == PhaseEvacMain && main_ok) fv = 1'b1;

      if (st_phase == PhaseEvacMain && main_ok && fore_ok) begin
        turbo_cmd = 1'b1;
        st_start  = now;
        st_phase  = PhaseRampTurbo;
      end

      if (st_phase == PhaseRampTurbo && speed < TurboMinHz &&
          ticks_since(now) > TurboTmoTicks) begin
        st_phase = PhaseError;
        st_err   = ErrTurboSlow;
      end

      if (st_phase == PhaseRampTurbo && speed > TurboMinHz && main_ok && fore_ok) begin
        bv = 1'b0;
        if (!st_lock) mv = 1'b1;
        st_start = now;
        st_phase = PhaseRunFpOn;
      end

      if (st_phase == PhaseRunFpOn && fore_v < off_v &&
          longint'(ticks_since(now)) > longint'(cycle_sec) * TicksPerSecond) begin
        fv       = 1'b0;
        st_phase = PhaseRunFpDown;
        st_start = now;
      end

      if (st_phase == PhaseRunFpDown && ticks_since(now) > ForeSettleTicks) begin
        fp       = 1'b0;
        st_phase = PhaseRunFpOff;
      end

      if (st_phase == PhaseRunFpOff && fore_v > on_v) begin
        fp       = 1'b1;
        st_phase = PhaseRunFpUp;
        st_start = now;
      end

      if (st_phase == PhaseRunFpUp && ticks_since(now) > ForeSettleTicks) begin
        fv       = 1'b1;
        st_phase = PhaseRunFpOn;
      end

      // Turn-off also leaves the error phase.
      if (!st_station && set_seen[0]) begin
        {fp, fv, mv, bv} = 4'b0000;
        turbo_cmd = 1'b0;
        vent_on   = 1'b1;
        st_phase  = PhaseOff;
        st_err    = ErrNone;
      end

      if (st_lock && !set_seen[1]) mv = 1'b0;

      if (!st_lock && set_seen[1] && st_station) begin
        st_start = now;
        st_phase = PhaseEvacFore;
        fp       = 1'b1;
        fv       = 1'b1;
      end

      set_seen = {st_lock, st_station};
    end

    r.fore_pump      = fp;
    r.fore_valve     = fv;
    r.main_valve     = mv;
    r.bypass_valve   = bv;
    r.turbo_run      = turbo_cmd;
    r.vent_enable    = vent_on;
    r.station_active = st_station;
    r.valves_locked  = st_lock;
    r.phase          = st_phase;
    r.error_code     = st_err;
    r.menu_request   = menu;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_phase   = PhaseOff;
      st_start   = '0;
      st_station = 1'b0;
      st_lock    = 1'b0;
      btn_seen   = '0;
      set_seen   = '0;
      {fp, fv, mv, bv} = 4'b0000;
      turbo_cmd  = 1'b0;
      vent_on    = 1'b1;
      st_err     = ErrNone;
      evac_min   = EvacTimeoutRst;
      cycle_sec  = ForeCycleRst;
      on_level   = ForeOnRst;
      off_level  = ForeOffRst;
      expected_results.delete();
      fail_total = 0;
      pending_o <= 0;
      fails_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegEvacTimeout: evac_min  = cfg_data_i[EvacMinW-1:0];
          RegForeCycle:   cycle_sec = cfg_data_i[CycleSecW-1:0];
          RegForeOn:      on_level  = cfg_data_i[OnLevelW-1:0];
          RegForeOff:     off_level = cfg_data_i[OffLevelW-1:0];
          default: ;
        endcase
      end

      // Compare before queuing this edge's item so a too-early result is caught.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("fore_pump",      want.fore_pump,      fore_pump_i);
          check_field("fore_valve",     want.fore_valve,     fore_valve_i);
          check_field("main_valve",     want.main_valve,     main_valve_i);
          check_field("bypass_valve",   want.bypass_valve,   bypass_valve_i);
          check_field("turbo_run",      want.turbo_run,      turbo_run_i);
          check_field("vent_enable",    want.vent_enable,    vent_enable_i);
          check_field("station_active", want.station_active, station_active_i);
          check_field("valves_locked",  want.valves_locked,  valves_locked_i);
          check_field("phase",          want.phase,          phase_i);
          check_field("error_code",     want.error_code,     error_code_i);
          check_field("menu_request",   want.menu_request,   menu_request_i);
        end
      end

      if (in_valid_i && in_ready_i)
        expected_results.push_back(poll_pass(now_ticks_i, fore_log_pressure_i,
                                             main_log_pressure_i, turbo_speed_hz_i,
                                             station_button_i, lock_button_i,
                                             menu_button_i, init_pass_i));

      pending_o <= expected_results.size();
      fails_o   <= fail_total;
    end
  end

endmodule

[test/tb.sv]
// Testbench top for vacuum_pump_station_sequencer_unit: drives poll items and registers.
// Depends on vpss_pkg, the unit itself and vpss_station_checker, which predicts and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vpss_pkg::*;

  // Give up after this many cycles in which neither channel moves an item.
  localparam int StallLimit = 2000;

  typedef enum logic [1:0] {RxFree, RxCoin, RxQuarter, RxLong} rx_mode_e;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx  = RegEvacTimeout;
  logic [CfgDataW-1:0]   cfg_data = '0;

  logic                  poll_valid  = 1'b0;
  logic                  poll_ready;
  logic [TimerW-1:0]     now_ticks   = '0;
  logic signed [LogW-1:0] fore_p     = '0;
  logic signed [LogW-1:0] main_p     = '0;
  logic [SpeedW-1:0]     speed_hz    = '0;
  logic                  btn_station = 1'b0;
  logic                  btn_lock    = 1'b0;
  logic                  btn_menu    = 1'b0;
  logic                  init_pass   = 1'b0;

  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic                  fore_pump, fore_valve, main_valve, bypass_valve;
  logic                  turbo_run, vent_enable, station_active, valves_locked;
  logic [PhaseW-1:0]     phase;
  logic [ErrW-1:0]       err_code;
  logic                  menu_req;

  int pending;
  int fails;

  // Sender pacing and the running station clock for well-formed sequences.
  logic              valid_up = 1'b0;
  int                burst_left = 0;
  logic [TimerW-1:0] seq_now = '0;
  int                cur_on  = 154;
  int                cur_off = -1280;

  rx_mode_e rx_mode = RxFree;
  logic [6:0] rx_cycle = '0;
  int idle_cycles = 0;

  vacuum_pump_station_sequencer_unit i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (poll_valid),
    .in_ready_o          (poll_ready),
    .now_ticks_i         (now_ticks),
    .fore_log_pressure_i (fore_p),
    .main_log_pressure_i (main_p),
    .turbo_speed_hz_i    (speed_hz),
    .station_button_i    (btn_station),
    .lock_button_i       (btn_lock),
    .menu_button_i       (btn_menu),
    .init_pass_i         (init_pass),
    .out_valid_o         (res_valid),
    .out_ready_i         (res_ready),
    .fore_pump_o         (fore_pump),
    .fore_valve_o        (fore_valve),
    .main_valve_o        (main_valve),
    .bypass_valve_o      (bypass_valve),
    .turbo_run_o         (turbo_run),
    .vent_enable_o       (vent_enable),
    .station_active_o    (station_active),
    .valves_locked_o     (valves_locked),
    .phase_o             (phase),
    .error_code_o        (err_code),
    .menu_request_o      (menu_req)
  );

  vpss_station_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (poll_valid),
    .in_ready_i          (poll_ready),
    .now_ticks_i         (now_ticks),
    .fore_log_pressure_i (fore_p),
    .main_log_pressure_i (main_p),
    .turbo_speed_hz_i    (speed_hz),
    .station_button_i    (btn_station),
    .lock_button_i       (btn_lock),
    .menu_button_i       (btn_menu),
    .init_pass_i         (init_pass),
    .out_valid_i         (res_valid),
    .out_ready_i         (res_ready),
    .fore_pump_i         (fore_pump),
    .fore_valve_i        (fore_valve),
    .main_valve_i        (main_valve),
    .bypass_valve_i      (bypass_valve),
    .turbo_run_i         (turbo_run),
    .vent_enable_i       (vent_enable),
    .station_active_i    (station_active),
    .valves_locked_i     (valves_locked),
    .phase_i             (phase),
    .error_code_i        (err_code),
    .menu_request_i      (menu_req),
    .pending_o           (pending),
    .fails_o             (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: switch between always-ready, coin-flip, one-in-four and long-stall patterns
  // each time the 7-bit rx_cycle counter wraps, so that stalls land on every phase of the station's work.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      rx_cycle  <= '0;
      rx_mode   <= RxFree;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (rx_cycle == '1) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RxFree:    res_ready <= 1'b1;
        RxCoin:    res_ready <= 1'($urandom_range(0, 1));
        RxQuarter: res_ready <= (rx_cycle[1:0] == 2'd0);
        default:   res_ready <= (rx_cycle[3:0] < 4'd4);
      endcase
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((poll_valid && poll_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[vacuum_pump_station_sequencer_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one poll item and hold it until accepted. Bursts of back-to-back items
  // alternate with short gaps; now and then a long burst keeps valid high throughout.
  task automatic send_poll(input logic [TimerW-1:0] t,
                           input logic signed [LogW-1:0] f,
                           input logic signed [LogW-1:0] m,
                           input logic [SpeedW-1:0] s,
                           input logic b_st, b_lk, b_mn, b_init);
    if (burst_left == 0) begin
      if (valid_up) begin
        poll_valid <= 1'b0;
        valid_up = 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    poll_valid  <= 1'b1;
    valid_up = 1'b1;
    now_ticks   <= t;
    fore_p      <= f;
    main_p      <= m;
    speed_hz    <= s;
    btn_station <= b_st;
    btn_lock    <= b_lk;
    btn_menu    <= b_mn;
    init_pass   <= b_init;
    do @(posedge clk); while (!poll_ready);
  endtask

  // Bias pressures toward vacuum so sequences get past the early phases, with some
  // weight on the zero boundary and on the configured fore-pump hysteresis levels.
  function automatic logic signed [LogW-1:0] pick_pressure(input logic fore_side);
    int unsigned roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 55)                    v = -int'($urandom_range(1, 3072));
    else if (roll < 65)               v = int'($urandom_range(0, 2)) - 1;
    else if (roll < 75 && fore_side)  v = cur_off + int'($urandom_range(0, 2)) - 1;
    else if (roll < 85 && fore_side)  v = cur_on + int'($urandom_range(0, 2)) - 1;
    else if (roll < 93)               v = int'($urandom_range(1, 1024));
    else                              v = int'($urandom_range(0, 8191)) - 4096;
    return LogW'(v);
  endfunction

  function automatic logic [SpeedW-1:0] pick_speed();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)      return SpeedW'($urandom_range(801, 4095));
    else if (roll < 75) return SpeedW'($urandom_range(799, 801));
    else if (roll < 90) return SpeedW'($urandom_range(0, 798));
    else                return SpeedW'($urandom_range(0, 4095));
  endfunction

  // Advance the station clock mostly by small steps, sometimes far enough to hit timeouts.
  task automatic send_random_poll();
    int unsigned roll;
    logic [TimerW-1:0] t;
    roll = $urandom_range(0, 99);
    if (roll < 75)      seq_now += $urandom_range(0, 400);
    else if (roll < 92) seq_now += $urandom_range(401, 2500);
    else if (roll < 98) seq_now += $urandom_range(2501, 12000);
    else                seq_now += $urandom_range(12001, 400000);
    t = seq_now;
    if ($urandom_range(0, 99) == 0) t = $urandom();
    if ($urandom_range(0, 99) < 4)
      // Noise: every field fully random.
      send_poll(t, LogW'($urandom()), LogW'($urandom()), SpeedW'($urandom()),
                1'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
    else
      send_poll(t, pick_pressure(1'b1), pick_pressure(1'b0), pick_speed(),
                $urandom_range(0, 199) < 3, $urandom_range(0, 99) < 2,
                $urandom_range(0, 99) < 5, $urandom_range(0, 99) < 15);
  endtask

  task automatic random_phase(input int n, input logic [TimerW-1:0] start_ticks);
    seq_now = start_ticks;
    repeat (n) send_random_poll();
  endtask

  // Drop valid, wait until every expected result has come, then idle before returning.
  task automatic wait_idle();
    if (valid_up) begin
      poll_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [CfgDataW-1:0] d_evac, d_cycle, d_on, d_off);
    wait_idle();
    put_reg(RegEvacTimeout, d_evac);
    put_reg(RegForeCycle,   d_cycle);
    put_reg(RegForeOn,      d_on);
    put_reg(RegForeOff,     d_off);
    cfg_we <= 1'b0;
    cur_on  = int'(d_on[OnLevelW-1:0]);
    cur_off = int'($signed(d_off[OffLevelW-1:0]));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at reset settings: idle, field extremes, then a full start-up
    // through every run phase, the menu request with and without init_pass, the
    // lock toggles, a buffer timeout, turn-off from error and a start across the wrap.
    send_poll(32'd0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'hFFFF_FFFF, -4096, 4095, 12'hFFF, 1'b0, 1'b0, 1'b0, 1'b1);
    send_poll(32'd1000, 100, 100, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1500, 100, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1501, 100, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1600, -1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1700, 0, -1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1800, -1, -1, 799, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd1900, -1, -1, 800, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd2000, -2000, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4000, -1281, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4001, -1281, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4301, -1280, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4400, 154, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4401, 155, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4701, 155, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd4800, -2000, -2000, 801, 1'b0, 1'b0, 1'b1, 1'b0);
    send_poll(32'd4900, -2000, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd5000, -2000, -2000, 801, 1'b0, 1'b0, 1'b1, 1'b0);
    send_poll(32'd5100, -2000, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b1);
    send_poll(32'd5200, -2000, -2000, 801, 1'b0, 1'b1, 1'b0, 1'b0);
    send_poll(32'd5300, -2000, -2000, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd5400, 100, 100, 801, 1'b0, 1'b1, 1'b0, 1'b0);
    send_poll(32'd95401, 100, 100, 801, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'd95500, 100, 100, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_poll(32'd95600, 100, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_poll(32'hFFFF_FF00, 100, 100, 0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_poll(32'h0000_0100, 100, 100, 0, 1'b0, 1'b0, 1'b0, 1'b0);

    // Random sequences under a series of settings: reset values, the low and high
    // ends, a random in-range set, out-of-range values (zero timeouts expire at once)
    // and raw random register data.
    random_phase(90, $urandom());
    write_config(CfgDataW'(10), CfgDataW'(10), CfgDataW'(0), CfgDataW'(-1536));
    random_phase(90, $urandom());
    write_config(CfgDataW'(120), CfgDataW'(600), CfgDataW'(256), CfgDataW'(0));
    random_phase(90, 32'hFFFF_F000);
    write_config(CfgDataW'($urandom_range(10, 120)), CfgDataW'($urandom_range(10, 600)),
                 CfgDataW'($urandom_range(0, 256)), CfgDataW'(-int'($urandom_range(0, 1536))));
    random_phase(90, $urandom());
    write_config(CfgDataW'(0), CfgDataW'(0), CfgDataW'(511), CfgDataW'(2047));
    random_phase(90, $urandom());
    write_config(CfgDataW'($urandom()), CfgDataW'($urandom()),
                 CfgDataW'($urandom()), CfgDataW'($urandom()));
    random_phase(90, $urandom());

    wait_idle();
    if (fails == 0 && pending == 0)
      $display("[vacuum_pump_station_sequencer_unit] OK");
    else
      $display("[vacuum_pump_station_sequencer_unit] ERROR");
    $finish;
  end

endmodule

[vacuum_pump_station_sequencer_unit.f]
src/vpss_pkg.sv
src/vacuum_pump_station_sequencer_unit.sv
src/vpss_checker.sv
test/vpss_station_checker.sv
test/tb.sv
